/* rtl/aroc_pkg.sv */
`timescale 1ns / 1ps

package aroc_pkg;

	localparam int unsigned ADC_FULL_SCALE_DEF = 4095;

	localparam int unsigned NOW_W = 32;
	localparam int unsigned RAW_W = 12;
	localparam int unsigned REF_W = 20;
	localparam int unsigned THR_W = 12;
	localparam int unsigned MS_W = 16;
	localparam int unsigned RES_W = 32;
	localparam int unsigned RNG_W = 2;
	localparam int unsigned STAT_W = 2;
	localparam int unsigned NUM_W = RES_W + 1;
	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = REF_W;
	localparam int unsigned IN_DATA_W = 48;
	localparam int unsigned OUT_DATA_W = 80;

	localparam logic [CFG_IDX_W-1:0] CFG_REF_LOW = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REF_MID = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REF_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 3'd7;

	localparam logic [RNG_W-1:0] RANGE_LOW = 2'd0;
	localparam logic [RNG_W-1:0] RANGE_MID = 2'd1;
	localparam logic [RNG_W-1:0] RANGE_HIGH = 2'd2;

	localparam logic [STAT_W-1:0] STAT_NONE = 2'd0;
	localparam logic [STAT_W-1:0] STAT_VALID = 2'd1;
	localparam logic [STAT_W-1:0] STAT_HIGH = 2'd2;

	localparam logic [REF_W-1:0] REF_LOW_RST = 20'd33;
	localparam logic [REF_W-1:0] REF_MID_RST = 20'd330;
	localparam logic [REF_W-1:0] REF_HIGH_RST = 20'd3300;
	localparam logic [THR_W-1:0] LOW_THR_RST = 12'd819;
	localparam logic [THR_W-1:0] HIGH_THR_RST = 12'd3072;
	localparam logic [MS_W-1:0] INTERVAL_RST = 16'd100;
	localparam logic [MS_W-1:0] RELEASE_RST = 16'd10;
	localparam logic [MS_W-1:0] SETTLE_RST = 16'd20;

	typedef enum logic [1:0] {
		MODE_MEASURE,
		MODE_RELEASE,
		MODE_SETTLE,
		MODE_FAULT
	} mode_t;

	typedef enum logic [1:0] {
		T_IDLE,
		T_EVAL,
		T_CONV,
		T_DONE
	} ctl_state_t;

	typedef enum logic [2:0] {
		C_IDLE,
		C_MUL,
		C_BIAS,
		C_DIV,
		C_DONE
	} conv_state_t;

	typedef struct packed {
		logic start;
		logic [REF_W-1:0] ref_ohm;
		logic [RAW_W-1:0] raw;
	} conv_req_t;

	typedef struct packed {
		logic done;
		logic [RES_W-1:0] resistance;
	} conv_rsp_t;

endpackage

/* rtl/aroc_conv.sv */
`timescale 1ns / 1ps

module aroc_conv import aroc_pkg::*; #(
	parameter int unsigned DEN_W = $clog2(ADC_FULL_SCALE_DEF + 1)
) (
	input  logic clk,
	input  logic arst_n,
	input  conv_req_t req,
	input  logic [DEN_W-1:0] den,
	output conv_rsp_t rsp
);

	conv_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [RES_W-1:0] mcand_q;
	logic [RAW_W-1:0] mplier_q;
	logic [NUM_W-1:0] acc_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0] rem_sh;
	logic [DEN_W:0] rem_diff;
	logic qbit;

	// One restoring division step: bring down the next numerator bit.
	assign rem_sh = {rem_q, acc_q[NUM_W-1]};
	assign rem_diff = rem_sh - {1'b0, den_q};
	assign qbit = (rem_sh >= {1'b0, den_q});

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			C_IDLE: begin
				if (req.start) begin
					state_d = C_MUL;
				end
			end
			C_MUL: begin
				if (cnt_q == CNT_W'(RAW_W - 1)) begin
					state_d = C_BIAS;
				end
			end
			C_BIAS: begin
				state_d = C_DIV;
			end
			C_DIV: begin
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					state_d = C_DONE;
				end
			end
			C_DONE: begin
				state_d = C_IDLE;
			end
			default: begin
				state_d = C_IDLE;
			end
		endcase
	end

	always_comb begin
		rsp.done = (state_q == C_DONE);
		rsp.resistance = acc_q[NUM_W-1] ? '1 : acc_q[RES_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == C_MUL && state_d == C_MUL) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (state_q == C_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				mcand_q <= RES_W'(req.ref_ohm);
				mplier_q <= req.raw;
				den_q <= den;
				acc_q <= '0;
				rem_q <= '0;
			end
			C_MUL: begin
				if (mplier_q[0]) begin
					acc_q <= acc_q + NUM_W'(mcand_q);
				end
				mcand_q <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
			end
			C_BIAS: begin
				acc_q <= acc_q + NUM_W'(den_q >> 1);
				rem_q <= '0;
			end
			C_DIV: begin
				rem_q <= qbit ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
				acc_q <= {acc_q[NUM_W-2:0], qbit};
			end
			default: begin
			end
		endcase
	end

endmodule

/* rtl/auto_ranging_ohmmeter_controller.sv */
`timescale 1ns / 1ps

// Auto-ranging ohmmeter controller.
// Each transfer on the s_ channel is one scheduler tick (time, converter
// sample and two status flags); each tick yields exactly one transfer on the
// m_ channel with relay drive, the latest measurement and the fault flag.
// Configuration registers are written through cfg_we, cfg_index and cfg_data;
// the user must do so only while no tick is in flight; the block does not enforce it.
// One tick is processed at a time. A tick that converts a sample passes
// through the bit-serial multiplier, a rounding step and the restoring
// divider (one quotient bit a cycle) in aroc_conv.
// s_tready is high only while no tick is in flight, so a new tick is not
// accepted until the previous one has been committed.
// The result waits in an output register; the next tick is accepted and
// processed while it waits and is held before commit until the output
// register is free, so a stalled receiver stalls the sender only then.
// Reset selects the middle range with its relay closed and starts the settle
// wait; the configuration and meter state registers return to their defaults.
module auto_ranging_ohmmeter_controller import aroc_pkg::*; #(
	parameter int unsigned ADC_FULL_SCALE = ADC_FULL_SCALE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// now_ms[31:0], adc_sample[43:32], adc_ok[44], select_ok[45], zero pad
	input  logic [IN_DATA_W-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// relay_on[0], relay_range[2:1], result_available[3], meas_status[5:4],
	// meas_sample[17:6], meas_resistance_ohm[49:18], meas_reference_ohm[69:50],
	// meas_active_range[71:70], meas_recommended_range[73:72], fault[74], zero pad
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned FS_W = $clog2(ADC_FULL_SCALE + 1);
	localparam int unsigned CMP_W = (FS_W > RAW_W) ? FS_W : RAW_W;

	// Configuration registers.
	logic [REF_W-1:0] ref_low_q, ref_mid_q, ref_high_q;
	logic [THR_W-1:0] low_thr_q, high_thr_q;
	logic [MS_W-1:0] interval_q, release_q, settle_q;

	// Captured tick.
	logic [NOW_W-1:0] now_q;
	logic [RAW_W-1:0] raw_q;
	logic adc_ok_q, sel_ok_q;
	logic [RES_W-1:0] res_q;

	// Meter state.
	mode_t mode_q, mode_d;
	logic [RNG_W-1:0] active_q, active_d, pending_q, pending_d;
	logic [NOW_W-1:0] start_ms_q, start_ms_d, last_ms_q, last_ms_d;
	logic started_q, started_d, avail_q, avail_d;
	logic [RAW_W-1:0] lat_sample_q, lat_sample_d;
	logic [RES_W-1:0] lat_res_q, lat_res_d;
	logic [REF_W-1:0] lat_ref_q, lat_ref_d;
	logic [RNG_W-1:0] lat_act_q, lat_act_d, lat_rec_q, lat_rec_d;
	logic [STAT_W-1:0] lat_status_q, lat_status_d;
	logic relay_on_q, relay_on_d;
	logic [RNG_W-1:0] relay_sel_q, relay_sel_d;

	// Control.
	ctl_state_t state_q, state_d;
	logic commit, out_free, m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q, m_tdata_d;
	conv_req_t conv_req;
	conv_rsp_t conv_rsp;

	// Tick evaluation.
	logic [NOW_W-1:0] elapsed, base_ms;
	logic [MS_W-1:0] limit_ms;
	logic time_up, due;
	logic [RNG_W-1:0] rec;
	logic [REF_W-1:0] cur_ref;
	logic over_top, raw_in_range, conv_ok, need_conv;
	logic [CMP_W-1:0] den_full;
	logic [FS_W-1:0] den;

	always_comb begin
		base_ms = (mode_q == MODE_MEASURE) ? last_ms_q : start_ms_q;
		case (mode_q)
			MODE_RELEASE: limit_ms = release_q;
			MODE_SETTLE: limit_ms = settle_q;
			default: limit_ms = interval_q;
		endcase
		elapsed = now_q - base_ms;
		time_up = (elapsed >= NOW_W'(limit_ms));
		due = !started_q || time_up;

		if (raw_q < low_thr_q && active_q != RANGE_LOW) begin
			rec = active_q - 1'b1;
		end else if (raw_q > high_thr_q && active_q != RANGE_HIGH) begin
			rec = active_q + 1'b1;
		end else begin
			rec = active_q;
		end

		case (active_q)
			RANGE_LOW: cur_ref = ref_low_q;
			RANGE_MID: cur_ref = ref_mid_q;
			default: cur_ref = ref_high_q;
		endcase

		over_top = (active_q == RANGE_HIGH) && (raw_q > high_thr_q);
		raw_in_range = (CMP_W'(raw_q) < CMP_W'(ADC_FULL_SCALE));
		conv_ok = (cur_ref != '0) && raw_in_range;
		den_full = CMP_W'(ADC_FULL_SCALE) - CMP_W'(raw_q);
		den = den_full[FS_W-1:0];
		need_conv = (mode_q == MODE_MEASURE) && due && adc_ok_q && (rec == active_q)
			&& !over_top && conv_ok;
	end

	// Next meter state for the tick under evaluation.
	always_comb begin
		mode_d = mode_q;
		active_d = active_q;
		pending_d = pending_q;
		start_ms_d = start_ms_q;
		last_ms_d = last_ms_q;
		started_d = started_q;
		avail_d = avail_q;
		lat_sample_d = lat_sample_q;
		lat_res_d = lat_res_q;
		lat_ref_d = lat_ref_q;
		lat_act_d = lat_act_q;
		lat_rec_d = lat_rec_q;
		lat_status_d = lat_status_q;
		relay_on_d = relay_on_q;
		relay_sel_d = relay_sel_q;
		unique case (mode_q)
			MODE_RELEASE: begin
				if (time_up) begin
					if (!sel_ok_q) begin
						relay_on_d = 1'b0;
						avail_d = 1'b0;
						lat_status_d = STAT_NONE;
						mode_d = MODE_FAULT;
					end else begin
						relay_on_d = 1'b1;
						relay_sel_d = pending_q;
						mode_d = MODE_SETTLE;
						start_ms_d = now_q;
					end
				end
			end
			MODE_SETTLE: begin
				if (time_up) begin
					active_d = pending_q;
					lat_act_d = pending_q;
					lat_rec_d = pending_q;
					lat_status_d = STAT_NONE;
					started_d = 1'b0;
					mode_d = MODE_MEASURE;
				end
			end
			MODE_MEASURE: begin
				if (due) begin
					last_ms_d = now_q;
					started_d = 1'b1;
					if (!adc_ok_q) begin
						avail_d = 1'b0;
					end else if (rec != active_q) begin
						avail_d = 1'b0;
						lat_status_d = STAT_NONE;
						pending_d = rec;
						relay_on_d = 1'b0;
						mode_d = MODE_RELEASE;
						start_ms_d = now_q;
					end else if (over_top) begin
						lat_sample_d = raw_q;
						lat_res_d = '0;
						lat_ref_d = cur_ref;
						lat_act_d = active_q;
						lat_rec_d = active_q;
						lat_status_d = STAT_HIGH;
						avail_d = 1'b1;
					end else if (!conv_ok) begin
						avail_d = 1'b0;
						lat_status_d = STAT_NONE;
					end else begin
						lat_sample_d = raw_q;
						lat_res_d = res_q;
						lat_ref_d = cur_ref;
						lat_act_d = active_q;
						lat_rec_d = rec;
						lat_status_d = STAT_VALID;
						avail_d = 1'b1;
					end
				end
			end
			MODE_FAULT: begin
			end
			default: begin
			end
		endcase
	end

	// Control state machine.
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			T_IDLE: begin
				if (s_tvalid) begin
					state_d = T_EVAL;
				end
			end
			T_EVAL: begin
				state_d = need_conv ? T_CONV : T_DONE;
			end
			T_CONV: begin
				if (conv_rsp.done) begin
					state_d = T_DONE;
				end
			end
			T_DONE: begin
				if (out_free) begin
					state_d = T_IDLE;
				end
			end
			default: begin
				state_d = T_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready = (state_q == T_IDLE);
		commit = (state_q == T_DONE) && out_free;
		conv_req.start = (state_q == T_EVAL) && need_conv;
		conv_req.ref_ohm = cur_ref;
		conv_req.raw = raw_q;
	end

	always_comb begin
		m_tdata_d = '0;
		m_tdata_d[0] = relay_on_d;
		m_tdata_d[2:1] = relay_sel_d;
		m_tdata_d[3] = avail_d;
		if (avail_d) begin
			m_tdata_d[5:4] = lat_status_d;
			m_tdata_d[17:6] = lat_sample_d;
			m_tdata_d[49:18] = lat_res_d;
			m_tdata_d[69:50] = lat_ref_d;
			m_tdata_d[71:70] = lat_act_d;
			m_tdata_d[73:72] = lat_rec_d;
		end
		m_tdata_d[74] = (mode_d == MODE_FAULT);
	end

	aroc_conv #(
		.DEN_W(FS_W)
	) u_conv (
		.clk(clk),
		.arst_n(arst_n),
		.req(conv_req),
		.den(den),
		.rsp(conv_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_low_q <= REF_LOW_RST;
			ref_mid_q <= REF_MID_RST;
			ref_high_q <= REF_HIGH_RST;
			low_thr_q <= LOW_THR_RST;
			high_thr_q <= HIGH_THR_RST;
			interval_q <= INTERVAL_RST;
			release_q <= RELEASE_RST;
			settle_q <= SETTLE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_REF_LOW: ref_low_q <= cfg_data;
				CFG_REF_MID: ref_mid_q <= cfg_data;
				CFG_REF_HIGH: ref_high_q <= cfg_data;
				CFG_LOW_THR: low_thr_q <= cfg_data[THR_W-1:0];
				CFG_HIGH_THR: high_thr_q <= cfg_data[THR_W-1:0];
				CFG_INTERVAL: interval_q <= cfg_data[MS_W-1:0];
				CFG_RELEASE: release_q <= cfg_data[MS_W-1:0];
				CFG_SETTLE: settle_q <= cfg_data[MS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			m_tvalid_q <= 1'b0;
			mode_q <= MODE_SETTLE;
			active_q <= RANGE_MID;
			pending_q <= RANGE_MID;
			start_ms_q <= '0;
			last_ms_q <= '0;
			started_q <= 1'b0;
			avail_q <= 1'b0;
			lat_sample_q <= '0;
			lat_res_q <= '0;
			lat_ref_q <= '0;
			lat_act_q <= RANGE_MID;
			lat_rec_q <= RANGE_MID;
			lat_status_q <= STAT_NONE;
			relay_on_q <= 1'b1;
			relay_sel_q <= RANGE_MID;
		end else begin
			state_q <= state_d;
			m_tvalid_q <= commit || (m_tvalid_q && !m_tready);
			if (commit) begin
				mode_q <= mode_d;
				active_q <= active_d;
				pending_q <= pending_d;
				start_ms_q <= start_ms_d;
				last_ms_q <= last_ms_d;
				started_q <= started_d;
				avail_q <= avail_d;
				lat_sample_q <= lat_sample_d;
				lat_res_q <= lat_res_d;
				lat_ref_q <= lat_ref_d;
				lat_act_q <= lat_act_d;
				lat_rec_q <= lat_rec_d;
				lat_status_q <= lat_status_d;
				relay_on_q <= relay_on_d;
				relay_sel_q <= relay_sel_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			now_q <= s_tdata[31:0];
			raw_q <= s_tdata[43:32];
			adc_ok_q <= s_tdata[44];
			sel_ok_q <= s_tdata[45];
		end
		if (conv_rsp.done) begin
			res_q <= conv_rsp.resistance;
		end
		if (commit) begin
			m_tdata_q <= m_tdata_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

`ifndef SYNTHESIS
	a_fault_relays_open: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[74] |-> !m_tdata[0])
		else $error("fault reported with a relay closed");

	a_unavail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[3] |-> m_tdata[73:4] == '0)
		else $error("measurement fields nonzero while unavailable");

	a_conv_in_measure: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == T_CONV |-> mode_q == MODE_MEASURE)
		else $error("conversion running outside measure mode");

	a_accept_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == T_EVAL && !s_tready)
		else $error("accepted tick not evaluated");
`endif

endmodule
